### src/mvc2d_pkg.sv
// shared types and codes for the multichannel valid convolution block
package mvc2d_pkg;

    // item kinds carried in s_tuser
    localparam logic [1:0] OP_LOAD_IMG = 2'd0;
    localparam logic [1:0] OP_LOAD_WGT = 2'd1;
    localparam logic [1:0] OP_COMPUTE  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_IN_CHANNELS = 3'd0;
    localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_IN_WIDTH    = 3'd2;
    localparam logic [2:0] REG_FILTER_SIZE = 3'd3;
    localparam logic [2:0] REG_NUM_FILTERS = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

### src/multichannel_valid_conv2d.sv
// multichannel valid 2d convolution with one shared multiply-accumulate unit
//
// Input items arrive on s_tvalid/s_tready with s_tuser holding the item kind.
// Image and weight loads are written into on-chip stores and give no result.
// A compute item runs a sequencer that walks channels, tap rows and tap
// columns, reading one sample and one weight per cycle into a single
// multiplier and accumulator, through the one read port of each store.
// An out-of-range compute skips the walk and returns zero with the error flag.
// s_tready is high only while the sequencer is idle.
// Results sit in an output register on m_tvalid/m_tdata/m_tuser; loads are
// still taken while a result waits, and a compute that finishes while the
// receiver stalls holds its sum until the register is free.
// Configuration is written over the APB port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// Reset clears the sequencer, the output valid and the registers to their
// defaults; the stores are not cleared and must be loaded before use.
module multichannel_valid_conv2d #(
    parameter int MAX_CH        = 4,
    parameter int MAX_DIM       = 32,
    parameter int MAX_FILT_SIZE = 7,
    parameter int MAX_FILTERS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // chan[1:0], row[6:2], col[11:7], filt[14:12], sample[30:15], zero[31]
    input  logic [31:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // acc_out[47:0]
    output logic [47:0] m_tdata,
    // bad_request[0]
    output logic        m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IMG_DEPTH = MAX_CH * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH = MAX_FILTERS * MAX_CH * MAX_FILT_SIZE * MAX_FILT_SIZE;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

    // configuration registers
    logic [2:0] in_channels_reg;
    logic [5:0] in_height_reg;
    logic [5:0] in_width_reg;
    logic [2:0] filter_size_reg;
    logic [3:0] num_filters_reg;

    // clamped working sizes
    logic [2:0] nch;
    logic [5:0] hgt;
    logic [5:0] wid;
    logic [2:0] ksz;
    logic [3:0] nfl;

    // input fields
    logic [1:0]  in_op;
    logic [1:0]  in_chan;
    logic [4:0]  in_row;
    logic [4:0]  in_col;
    logic [2:0]  in_filt;
    logic [15:0] in_sample;

    // sequencer
    mvc2d_pkg::state_t state_reg, state_next;
    logic [4:0] row_reg;
    logic [4:0] col_reg;
    logic [2:0] filt_reg;
    logic [2:0] ic_reg;
    logic [2:0] fr_reg;
    logic [2:0] fc_reg;
    logic       issue;
    logic       last_tap;

    // datapath
    logic [IMG_AW-1:0]  img_waddr;
    logic [IMG_AW-1:0]  img_raddr;
    logic [WGT_AW-1:0]  wgt_waddr;
    logic [WGT_AW-1:0]  wgt_raddr;
    logic [15:0]        img_mem [IMG_DEPTH];
    logic [15:0]        wgt_mem [WGT_DEPTH];
    logic [15:0]        img_q_reg;
    logic [15:0]        wgt_q_reg;
    logic               rd_valid_reg;
    logic signed [31:0] prod_reg;
    logic               prod_valid_reg;
    logic signed [47:0] acc_reg;
    logic               bad_reg;

    // output register
    logic        out_valid_reg;
    logic [47:0] out_acc_reg;
    logic        out_bad_reg;

    logic in_fire;
    logic img_we;
    logic wgt_we;
    logic cmp_fire;
    logic cmp_ok;
    logic out_load;
    logic cfg_we;

    // field unpacking
    assign in_op     = s_tuser;
    assign in_chan   = s_tdata[1:0];
    assign in_row    = s_tdata[6:2];
    assign in_col    = s_tdata[11:7];
    assign in_filt   = s_tdata[14:12];
    assign in_sample = s_tdata[30:15];

    // register clamping into the usable range
    always_comb
    begin
        nch = (in_channels_reg == 3'd0) ? 3'd1 :
              (in_channels_reg > MAX_CH) ? 3'(MAX_CH) : in_channels_reg;
        hgt = (in_height_reg == 6'd0) ? 6'd1 :
              (in_height_reg > MAX_DIM) ? 6'(MAX_DIM) : in_height_reg;
        wid = (in_width_reg == 6'd0) ? 6'd1 :
              (in_width_reg > MAX_DIM) ? 6'(MAX_DIM) : in_width_reg;
        ksz = (filter_size_reg == 3'd0) ? 3'd1 :
              (filter_size_reg > MAX_FILT_SIZE) ? 3'(MAX_FILT_SIZE) : filter_size_reg;
        nfl = (num_filters_reg == 4'd0) ? 4'd1 :
              (num_filters_reg > MAX_FILTERS) ? 4'(MAX_FILTERS) : num_filters_reg;
    end

    // configuration write and read
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channels_reg <= 3'd1;
            in_height_reg   <= 6'd32;
            in_width_reg    <= 6'd32;
            filter_size_reg <= 3'd3;
            num_filters_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                mvc2d_pkg::REG_IN_CHANNELS: in_channels_reg <= pwdata[2:0];
                mvc2d_pkg::REG_IN_HEIGHT:   in_height_reg   <= pwdata[5:0];
                mvc2d_pkg::REG_IN_WIDTH:    in_width_reg    <= pwdata[5:0];
                mvc2d_pkg::REG_FILTER_SIZE: filter_size_reg <= pwdata[2:0];
                mvc2d_pkg::REG_NUM_FILTERS: num_filters_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            mvc2d_pkg::REG_IN_CHANNELS: prdata = {29'd0, in_channels_reg};
            mvc2d_pkg::REG_IN_HEIGHT:   prdata = {26'd0, in_height_reg};
            mvc2d_pkg::REG_IN_WIDTH:    prdata = {26'd0, in_width_reg};
            mvc2d_pkg::REG_FILTER_SIZE: prdata = {29'd0, filter_size_reg};
            mvc2d_pkg::REG_NUM_FILTERS: prdata = {28'd0, num_filters_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // item decode
    assign s_tready = (state_reg == mvc2d_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign img_we   = in_fire && (in_op == mvc2d_pkg::OP_LOAD_IMG) &&
                      ({1'b0, in_chan} < nch) && ({1'b0, in_row} < hgt) &&
                      ({1'b0, in_col} < wid);
    assign wgt_we   = in_fire && (in_op == mvc2d_pkg::OP_LOAD_WGT) &&
                      ({1'b0, in_filt} < nfl) && ({1'b0, in_chan} < nch) &&
                      (in_row < {2'b00, ksz}) && (in_col < {2'b00, ksz});
    assign cmp_fire = in_fire && (in_op == mvc2d_pkg::OP_COMPUTE);
    assign cmp_ok   = ({1'b0, in_filt} < nfl) &&
                      (({2'b00, in_row} + {4'b0000, ksz}) <= {1'b0, hgt}) &&
                      (({2'b00, in_col} + {4'b0000, ksz}) <= {1'b0, wid});

    // store addresses for loads and for the tap walk
    assign img_waddr = IMG_AW'((IMG_AW'(in_chan) * IMG_AW'(MAX_DIM) + IMG_AW'(in_row))
                       * IMG_AW'(MAX_DIM) + IMG_AW'(in_col));
    assign wgt_waddr = WGT_AW'(((WGT_AW'(in_filt) * WGT_AW'(MAX_CH) + WGT_AW'(in_chan))
                       * WGT_AW'(MAX_FILT_SIZE) + WGT_AW'(in_row))
                       * WGT_AW'(MAX_FILT_SIZE) + WGT_AW'(in_col));
    assign img_raddr = IMG_AW'((IMG_AW'(ic_reg) * IMG_AW'(MAX_DIM)
                       + IMG_AW'(row_reg) + IMG_AW'(fr_reg))
                       * IMG_AW'(MAX_DIM) + IMG_AW'(col_reg) + IMG_AW'(fc_reg));
    assign wgt_raddr = WGT_AW'(((WGT_AW'(filt_reg) * WGT_AW'(MAX_CH) + WGT_AW'(ic_reg))
                       * WGT_AW'(MAX_FILT_SIZE) + WGT_AW'(fr_reg))
                       * WGT_AW'(MAX_FILT_SIZE) + WGT_AW'(fc_reg));

    // image store
    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= in_sample;
        end
        if (issue)
        begin
            img_q_reg <= img_mem[img_raddr];
        end
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_waddr] <= in_sample;
        end
        if (issue)
        begin
            wgt_q_reg <= wgt_mem[wgt_raddr];
        end
    end

    // sequencer next state
    assign issue    = (state_reg == mvc2d_pkg::ST_RUN);
    assign last_tap = (ic_reg == 3'(nch - 3'd1)) && (fr_reg == 3'(ksz - 3'd1)) &&
                      (fc_reg == 3'(ksz - 3'd1));
    assign out_load = (state_reg == mvc2d_pkg::ST_FINISH) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvc2d_pkg::ST_IDLE:
            begin
                if (cmp_fire)
                begin
                    state_next = cmp_ok ? mvc2d_pkg::ST_RUN : mvc2d_pkg::ST_FINISH;
                end
            end
            mvc2d_pkg::ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = mvc2d_pkg::ST_DRAIN;
                end
            end
            mvc2d_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !prod_valid_reg)
                begin
                    state_next = mvc2d_pkg::ST_FINISH;
                end
            end
            mvc2d_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = mvc2d_pkg::ST_IDLE;
                end
            end
            default: state_next = mvc2d_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mvc2d_pkg::ST_IDLE;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // request capture and tap counters
    always_ff @(posedge clk)
    begin
        if (cmp_fire)
        begin
            row_reg  <= in_row;
            col_reg  <= in_col;
            filt_reg <= in_filt;
            ic_reg   <= 3'd0;
            fr_reg   <= 3'd0;
            fc_reg   <= 3'd0;
        end
        else if (issue)
        begin
            if (fc_reg == 3'(ksz - 3'd1))
            begin
                fc_reg <= 3'd0;
                if (fr_reg == 3'(ksz - 3'd1))
                begin
                    fr_reg <= 3'd0;
                    ic_reg <= ic_reg + 3'd1;
                end
                else
                begin
                    fr_reg <= fr_reg + 3'd1;
                end
            end
            else
            begin
                fc_reg <= fc_reg + 3'd1;
            end
        end
    end

    // shared multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod_reg <= $signed(img_q_reg) * $signed(wgt_q_reg);
        end
        if (cmp_fire)
        begin
            acc_reg <= 48'sd0;
            bad_reg <= !cmp_ok;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + {{16{prod_reg[31]}}, prod_reg};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_acc_reg <= acc_reg;
            out_bad_reg <= bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_acc_reg;
    assign m_tuser  = out_bad_reg;

endmodule

### dv/tb_top.sv
// self-checking testbench for the multichannel valid convolution block
module tb_top;

    localparam int MAX_CH        = 4;
    localparam int MAX_DIM       = 32;
    localparam int MAX_FILT_SIZE = 7;
    localparam int MAX_FILTERS   = 8;
    localparam int IMG_DEPTH     = MAX_CH * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH     = MAX_FILTERS * MAX_CH * MAX_FILT_SIZE * MAX_FILT_SIZE;

    // op code the block ignores, and a register slot with nothing behind it
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    localparam int PLAN_LEN    = 8;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;
    localparam int END_SETTLE  = 50;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [47:0] acc;
        logic        bad;
    } conv_result_t;

    // stores, size registers and the queue of sums still owed by the block
    class conv_bank;
        logic [2:0]   chans_raw;
        logic [5:0]   height_raw;
        logic [5:0]   width_raw;
        logic [2:0]   ksize_raw;
        logic [3:0]   nfilt_raw;
        logic [15:0]  img_mem [IMG_DEPTH];
        logic [15:0]  wgt_mem [WGT_DEPTH];
        bit           img_set [IMG_DEPTH];
        bit           wgt_set [WGT_DEPTH];
        conv_result_t pending_sums [$];
        int unsigned  fail_count;
        int unsigned  sums_checked;
        int unsigned  bad_seen;
        int unsigned  loads_taken;

        function new();
            chans_raw  = 3'd1;
            height_raw = 6'd32;
            width_raw  = 6'd32;
            ksize_raw  = 3'd3;
            nfilt_raw  = 4'd1;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                mvc2d_pkg::REG_IN_CHANNELS: chans_raw  = value[2:0];
                mvc2d_pkg::REG_IN_HEIGHT:   height_raw = value[5:0];
                mvc2d_pkg::REG_IN_WIDTH:    width_raw  = value[5:0];
                mvc2d_pkg::REG_FILTER_SIZE: ksize_raw  = value[2:0];
                mvc2d_pkg::REG_NUM_FILTERS: nfilt_raw  = value[3:0];
                default: ;
            endcase
        endfunction

        // registers are used saturated into their legal range
        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned chans();
            return clamp_size(32'(chans_raw), MAX_CH);
        endfunction
        function int unsigned rows();
            return clamp_size(32'(height_raw), MAX_DIM);
        endfunction
        function int unsigned cols();
            return clamp_size(32'(width_raw), MAX_DIM);
        endfunction
        function int unsigned ksize();
            return clamp_size(32'(ksize_raw), MAX_FILT_SIZE);
        endfunction
        function int unsigned nfilt();
            return clamp_size(32'(nfilt_raw), MAX_FILTERS);
        endfunction

        function int unsigned img_addr(int unsigned ch, int unsigned r, int unsigned c);
            return (ch * MAX_DIM + r) * MAX_DIM + c;
        endfunction

        function int unsigned wgt_addr(int unsigned f, int unsigned ch, int unsigned r,
                                       int unsigned c);
            return ((f * MAX_CH + ch) * MAX_FILT_SIZE + r) * MAX_FILT_SIZE + c;
        endfunction

        function bit load_hits(logic [1:0] op, int unsigned ch, int unsigned r,
                               int unsigned c, int unsigned f);
            if (op == mvc2d_pkg::OP_LOAD_IMG)
                return ch < chans() && r < rows() && c < cols();
            if (op == mvc2d_pkg::OP_LOAD_WGT)
                return f < nfilt() && ch < chans() && r < ksize() && c < ksize();
            return 1'b0;
        endfunction

        function bit request_ok(int unsigned f, int unsigned r, int unsigned c);
            return f < nfilt() && ksize() <= rows() && ksize() <= cols()
                && r <= rows() - ksize() && c <= cols() - ksize();
        endfunction

        // every sample and weight under the window has been written
        function bit window_loaded(int unsigned f, int unsigned r, int unsigned c);
            int unsigned ic, fr, fc;
            for (ic = 0; ic < chans(); ic++)
                for (fr = 0; fr < ksize(); fr++)
                    for (fc = 0; fc < ksize(); fc++)
                        if (!img_set[img_addr(ic, r + fr, c + fc)]
                            || !wgt_set[wgt_addr(f, ic, fr, fc)])
                            return 1'b0;
            return 1'b1;
        endfunction

        // apply one accepted item: store a load or queue the sum it owes
        function void take_item(logic [1:0] op, int unsigned ch, int unsigned r,
                                int unsigned c, int unsigned f, logic [15:0] sample);
            conv_result_t res;
            longint       sum;
            longint       s;
            longint       wv;
            int unsigned  ic, fr, fc;
            if (op == mvc2d_pkg::OP_LOAD_IMG && load_hits(op, ch, r, c, f)) begin
                img_mem[img_addr(ch, r, c)] = sample;
                img_set[img_addr(ch, r, c)] = 1'b1;
                loads_taken++;
            end
            else if (op == mvc2d_pkg::OP_LOAD_WGT && load_hits(op, ch, r, c, f)) begin
                wgt_mem[wgt_addr(f, ch, r, c)] = sample;
                wgt_set[wgt_addr(f, ch, r, c)] = 1'b1;
                loads_taken++;
            end
            else if (op == mvc2d_pkg::OP_COMPUTE) begin
                sum = 0;
                res.bad = !request_ok(f, r, c);
                if (!res.bad) begin
                    for (ic = 0; ic < chans(); ic++)
                        for (fr = 0; fr < ksize(); fr++)
                            for (fc = 0; fc < ksize(); fc++) begin
                                s  = longint'($signed(img_mem[img_addr(ic, r + fr, c + fc)]));
                                wv = longint'($signed(wgt_mem[wgt_addr(f, ic, fr, fc)]));
                                sum += s * wv;
                            end
                end
                res.acc = sum[47:0];
                pending_sums.insert(pending_sums.size(), res);
            end
        endfunction

        // compare one delivered result with the oldest owed sum
        function void match_sum(logic [47:0] acc, logic bad);
            conv_result_t want;
            if (pending_sums.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: acc %h bad %b", acc, bad);
                return;
            end
            want = pending_sums.pop_front();
            sums_checked++;
            if (want.bad)
                bad_seen++;
            if (want.acc !== acc || want.bad !== bad) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d mismatch: expected acc %h bad %b, got acc %h bad %b",
                             sums_checked, want.acc, want.bad, acc, bad);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // chan[1:0], row[6:2], col[11:7], filt[14:12], sample[30:15], zero[31]
    logic [31:0] s_tdata  = '0;
    // op[1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // acc_out[47:0]
    logic [47:0] m_tdata;
    // bad_request[0]
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    conv_bank    bank;
    int unsigned items_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned settings_run = 1;
    int unsigned holds_asked  = 0;

    // size settings: in_channels, in_height, in_width, filter_size, num_filters
    int unsigned size_plan [0:PLAN_LEN-1][0:4] = '{
        '{2, 8, 8, 3, 2},
        '{4, 6, 9, 7, 8},
        '{1, 1, 1, 1, 1},
        '{0, 0, 63, 0, 0},
        '{3, 12, 5, 4, 3},
        '{7, 63, 63, 7, 15},
        '{2, 16, 16, 2, 4},
        '{4, 32, 32, 1, 8}
    };
    logic [2:0]  reg_index [0:4] = '{mvc2d_pkg::REG_IN_CHANNELS, mvc2d_pkg::REG_IN_HEIGHT,
                                     mvc2d_pkg::REG_IN_WIDTH, mvc2d_pkg::REG_FILTER_SIZE,
                                     mvc2d_pkg::REG_NUM_FILTERS};
    int unsigned reg_field_max [0:4] = '{7, 63, 63, 7, 15};

    multichannel_valid_conv2d u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly random values, with the extremes now and then
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one item, in bursts with random gaps, and wait for its handshake
    task automatic send_item(input logic [1:0] op, input int unsigned ch,
                             input int unsigned r, input int unsigned c,
                             input int unsigned f, input logic [15:0] sample);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_sent++;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, sample, 3'(f), 5'(c), 5'(r), 2'(ch)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering until every owed sum has come back, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bank.pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        bank.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write whatever the window still lacks
    task automatic fill_window(input int unsigned f, input int unsigned r,
                               input int unsigned c);
        int unsigned ic, fr, fc;
        for (ic = 0; ic < bank.chans(); ic++)
            for (fr = 0; fr < bank.ksize(); fr++)
                for (fc = 0; fc < bank.ksize(); fc++) begin
                    if (!bank.img_set[bank.img_addr(ic, r + fr, c + fc)])
                        send_item(mvc2d_pkg::OP_LOAD_IMG, ic, r + fr, c + fc, $urandom,
                                  rand_sample());
                    if (!bank.wgt_set[bank.wgt_addr(f, ic, fr, fc)])
                        send_item(mvc2d_pkg::OP_LOAD_WGT, ic, fr, fc, f, rand_sample());
                end
    endtask

    // random traffic under the current sizes until the budget is used
    task automatic run_random(input int unsigned budget);
        int unsigned stop_at, pick, k, lim_r, lim_c;
        logic [1:0]  op;
        int unsigned r, c;
        int unsigned f;
        int unsigned last_r, last_c;
        int unsigned last_f;
        bit          have_last;
        stop_at   = items_sent + budget;
        have_last = 1'b0;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            k    = bank.ksize();
            if (pick < 55) begin
                // well-formed: touch up the window, fill the gaps, then ask for the sum
                if (k <= bank.rows() && k <= bank.cols()) begin
                    if (!(have_last && $urandom_range(0, 1)
                          && bank.request_ok(last_f, last_r, last_c))) begin
                        last_f    = $urandom_range(0, bank.nfilt() - 1);
                        last_r    = $urandom_range(0, bank.rows() - k);
                        last_c    = $urandom_range(0, bank.cols() - k);
                        have_last = 1'b1;
                    end
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 1))
                            send_item(mvc2d_pkg::OP_LOAD_IMG,
                                      $urandom_range(0, bank.chans() - 1),
                                      last_r + $urandom_range(0, k - 1),
                                      last_c + $urandom_range(0, k - 1), $urandom,
                                      rand_sample());
                        else
                            send_item(mvc2d_pkg::OP_LOAD_WGT,
                                      $urandom_range(0, bank.chans() - 1),
                                      $urandom_range(0, k - 1), $urandom_range(0, k - 1),
                                      last_f, rand_sample());
                    end
                    fill_window(last_f, last_r, last_c);
                    send_item(mvc2d_pkg::OP_COMPUTE, $urandom, last_r, last_c, last_f,
                              rand_sample());
                end
                else begin
                    send_item(mvc2d_pkg::OP_COMPUTE, $urandom, $urandom, $urandom, $urandom,
                              rand_sample());
                end
            end
            else if (pick < 70) begin
                // compute near and past the edges of the output
                if ($urandom_range(0, 3) == 0) begin
                    f = $urandom_range(0, 7);
                    r = $urandom_range(0, 31);
                    c = $urandom_range(0, 31);
                end
                else begin
                    f = $urandom_range(0, bank.nfilt() < 7 ? bank.nfilt() : 7);
                    r = $urandom_range(0, bank.rows() < 31 ? bank.rows() : 31);
                    c = $urandom_range(0, bank.cols() < 31 ? bank.cols() : 31);
                end
                if (bank.request_ok(f, r, c) && !bank.window_loaded(f, r, c))
                    fill_window(f, r, c);
                send_item(mvc2d_pkg::OP_COMPUTE, $urandom, r, c, f, rand_sample());
            end
            else if (pick < 94) begin
                // loads, mostly in range, some just beyond it
                op = $urandom_range(0, 1) ? mvc2d_pkg::OP_LOAD_WGT : mvc2d_pkg::OP_LOAD_IMG;
                lim_r = (op == mvc2d_pkg::OP_LOAD_IMG) ? bank.rows() : k;
                lim_c = (op == mvc2d_pkg::OP_LOAD_IMG) ? bank.cols() : k;
                if ($urandom_range(0, 5) == 0)
                    send_item(op, $urandom, $urandom, $urandom, $urandom, rand_sample());
                else
                    send_item(op, $urandom_range(0, bank.chans() < 3 ? bank.chans() : 3),
                              $urandom_range(0, lim_r < 31 ? lim_r : 31),
                              $urandom_range(0, lim_c < 31 ? lim_c : 31),
                              $urandom_range(0, bank.nfilt() < 7 ? bank.nfilt() : 7),
                              rand_sample());
            end
            else if (pick < 99) begin
                send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, rand_sample());
            end
            else begin
                wait_drained();
            end
        end
    endtask

    // result side: stretches of random readiness, plus long hold-offs on request
    initial
    begin : result_sink
        int unsigned span, ready_pct, held, holds_done;
        span = 0;
        ready_pct = 100;
        holds_done = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (holds_asked != holds_done) begin
                m_tready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                holds_done++;
            end
            else begin
                if (span == 0) begin
                    span      = $urandom_range(20, 250);
                    ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 90);
                end
                span--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge clk);
            end
        end
    end

    // watch both streams at each edge, check results and keep the watchdog
    always @(posedge clk)
    begin : bus_watch
        if (rst_n) begin
            if (m_tvalid && m_tready)
                bank.match_sum(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                bank.take_item(s_tuser, 32'(s_tdata[1:0]), 32'(s_tdata[6:2]),
                               32'(s_tdata[11:7]), 32'(s_tdata[14:12]), s_tdata[30:15]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        int unsigned p, i, r, c;
        bank = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored items first, then a 3x3 window at full negative scale
        send_item(OP_NONE, 3, 31, 31, 7, 16'hffff);
        send_item(mvc2d_pkg::OP_LOAD_IMG, 3, 31, 31, 0, 16'h1234);
        send_item(mvc2d_pkg::OP_LOAD_WGT, 3, 6, 6, 7, 16'h4321);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++) begin
                send_item(mvc2d_pkg::OP_LOAD_IMG, 0, r, c, 0, 16'h8000);
                send_item(mvc2d_pkg::OP_LOAD_WGT, 0, r, c, 0, 16'h8000);
            end
        send_item(mvc2d_pkg::OP_COMPUTE, 0, 0, 0, 0, 16'h0000);
        send_item(mvc2d_pkg::OP_LOAD_WGT, 0, 0, 0, 0, 16'h7fff);
        send_item(mvc2d_pkg::OP_LOAD_IMG, 0, 2, 2, 0, 16'h0000);
        send_item(mvc2d_pkg::OP_COMPUTE, 1, 0, 0, 0, 16'hffff);
        // filter beyond the bank, then an output row past the image
        send_item(mvc2d_pkg::OP_COMPUTE, 0, 0, 0, 1, 16'h0000);
        send_item(mvc2d_pkg::OP_COMPUTE, 0, 30, 0, 0, 16'h0000);
        run_random(150);

        // walk through the size settings, a few of them random
        for (p = 0; p < PLAN_LEN + 2; p++) begin
            wait_drained();
            for (i = 0; i < 5; i++)
                write_reg(reg_index[i], (p < PLAN_LEN) ? size_plan[p][i]
                                                       : $urandom_range(0, reg_field_max[i]));
            if (p == 0)
                write_reg(REG_UNUSED, $urandom);
            settings_run++;
            if (p == 0 || p == 6)
                holds_asked++;
            run_random(160);
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        $display("covered %0d size settings with %0d loads stored and %0d results checked,",
                 settings_run, bank.loads_taken, bank.sums_checked);
        $display("%0d of them out-of-range requests, %0d mismatches",
                 bank.bad_seen, bank.fail_count);
        if (bank.fail_count == 0 && bank.pending_sums.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### multichannel_valid_conv2d.f
src/mvc2d_pkg.sv
src/multichannel_valid_conv2d.sv
dv/tb_top.sv
